// ----- rtl/pgc_pkg.sv -----
// Package for the pointer gesture classifier.
// Holds widths and codes shared by the top level and its checker, and the top level's result record.
// Depends on nothing.
package pgc_pkg;

  localparam int CoordBits  = 16;
  localparam int TickBits   = 16;
  localparam int RadiusBits = 10;
  localparam int TicksBits  = 16;
  localparam int CfgBits    = 16;
  localparam int CfgIdxBits = 1;

  // Offsets beyond this magnitude are never close to the anchor.
  localparam int FarLimit   = 1023;
  localparam int MagBits    = 10;
  localparam int SqBits     = 2 * MagBits;

  localparam int FifoDepth  = 4;
  localparam int FifoAw     = $clog2(FifoDepth);

  localparam logic [CfgIdxBits-1:0] CfgClickRadius   = 1'b0;
  localparam logic [CfgIdxBits-1:0] CfgLongPressTick = 1'b1;

  typedef enum logic [1:0] {
    CmdDown   = 2'd0,
    CmdUp     = 2'd1,
    CmdMotion = 2'd2,
    CmdTick   = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    GClick      = 3'd0,
    GLongBegin  = 3'd1,
    GLongMotion = 3'd2,
    GLongEnd    = 3'd3,
    GDragBegin  = 3'd4,
    GDragMotion = 3'd5,
    GDragEnd    = 3'd6
  } gesture_e;

  typedef struct packed {
    gesture_e                    gesture;
    logic signed [CoordBits-1:0] out_x;
    logic signed [CoordBits-1:0] out_y;
    logic signed [CoordBits:0]   offset_x;
    logic signed [CoordBits:0]   offset_y;
    logic                        last;
  } result_t;

endpackage

// ----- rtl/pointer_gesture_classifier.sv -----
// Pointer gesture classifier: input register, combinational classification and a result queue.
// Depends on pgc_pkg for widths, command and gesture codes and the result record.
//
// Flow: an accepted beat is classified from the input register once the queue has room, its
// results are written to the queue, and the queue head then holds the first of them.
// Throughput: one input beat per cycle while each event gives at most one result and the
// output drains; a release that gives two results needs two output transfers, as the
// single output port and the four-entry result queue pace the block.
// Reset: rst_ni clears the gesture state, the queue and the input stage at once and sets
// click_radius to 10 and long_press_ticks to 500.
module pointer_gesture_classifier (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Configuration write port.
  input  logic                                 cfg_we_i,
  input  logic [pgc_pkg::CfgIdxBits-1:0]       cfg_idx_i,
  input  logic [pgc_pkg::CfgBits-1:0]          cfg_data_i,
  // Input event channel.
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [1:0]                           cmd_i,
  input  logic signed [pgc_pkg::CoordBits-1:0] pos_x_i,
  input  logic signed [pgc_pkg::CoordBits-1:0] pos_y_i,
  input  logic                                 consumed_i,
  input  logic                                 left_held_i,
  input  logic                                 is_left_button_i,
  // Gesture result channel.
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [2:0]                           gesture_o,
  output logic signed [pgc_pkg::CoordBits-1:0] out_x_o,
  output logic signed [pgc_pkg::CoordBits-1:0] out_y_o,
  output logic signed [pgc_pkg::CoordBits:0]   offset_x_o,
  output logic signed [pgc_pkg::CoordBits:0]   offset_y_o,
  output logic                                 last_o
);

  localparam int C = pgc_pkg::CoordBits;

  // ---------------------------------------------------------------------------
  // Configuration. The click radius is kept squared, so the closeness test
  // needs no multiplier on the radius side.
  // ---------------------------------------------------------------------------
  logic [pgc_pkg::SqBits-1:0]    radius_sq_q;
  logic [pgc_pkg::TicksBits-1:0] long_ticks_q;
  logic [pgc_pkg::SqBits-1:0]    cfg_radius;

  assign cfg_radius = pgc_pkg::SqBits'(cfg_data_i[pgc_pkg::RadiusBits-1:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_sq_q  <= pgc_pkg::SqBits'(100);
      long_ticks_q <= pgc_pkg::TicksBits'(500);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pgc_pkg::CfgClickRadius: begin
          radius_sq_q <= pgc_pkg::SqBits'(cfg_radius * cfg_radius);
        end
        pgc_pkg::CfgLongPressTick: begin
          long_ticks_q <= cfg_data_i[pgc_pkg::TicksBits-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Input register. It refills in the same cycle that its beat is classified.
  // ---------------------------------------------------------------------------
  logic                  in_valid_q;
  logic [1:0]            cmd_q;
  logic signed [C-1:0]   pos_x_q;
  logic signed [C-1:0]   pos_y_q;
  logic                  consumed_q;
  logic                  left_held_q;
  logic                  is_left_q;

  logic                  space_ok;
  logic                  fire;

  assign fire       = in_valid_q && space_ok;
  assign in_ready_o = !in_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      cmd_q       <= cmd_i;
      pos_x_q     <= pos_x_i;
      pos_y_q     <= pos_y_i;
      consumed_q  <= consumed_i;
      left_held_q <= left_held_i;
      is_left_q   <= is_left_button_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Gesture state.
  // ---------------------------------------------------------------------------
  logic signed [C-1:0]            anchor_x_q, anchor_x_d;
  logic signed [C-1:0]            anchor_y_q, anchor_y_d;
  logic                           anchor_valid_q, anchor_valid_d;
  logic [pgc_pkg::TickBits-1:0]   elapsed_q, elapsed_d;
  logic                           long_active_q, long_active_d;
  logic                           drag_active_q, drag_active_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      anchor_x_q     <= '0;
      anchor_y_q     <= '0;
      anchor_valid_q <= 1'b0;
      elapsed_q      <= '0;
      long_active_q  <= 1'b0;
      drag_active_q  <= 1'b0;
    end else if (fire) begin
      anchor_x_q     <= anchor_x_d;
      anchor_y_q     <= anchor_y_d;
      anchor_valid_q <= anchor_valid_d;
      elapsed_q      <= elapsed_d;
      long_active_q  <= long_active_d;
      drag_active_q  <= drag_active_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Closeness test: the offset from the anchor is checked against the far
  // limit first, so the squares only ever see ten-bit magnitudes.
  // ---------------------------------------------------------------------------
  logic signed [C:0]              dx, dy;
  logic [C:0]                     mag_x, mag_y;
  logic                           far;
  logic [pgc_pkg::SqBits-1:0]     sq_x, sq_y;
  logic [pgc_pkg::SqBits:0]       dist_sq;
  logic                           close;

  assign dx    = (C+1)'(pos_x_q) - (C+1)'(anchor_x_q);
  assign dy    = (C+1)'(pos_y_q) - (C+1)'(anchor_y_q);
  assign mag_x = dx[C] ? (C+1)'(-dx) : (C+1)'(dx);
  assign mag_y = dy[C] ? (C+1)'(-dy) : (C+1)'(dy);
  assign far   = (32'(mag_x) > 32'(pgc_pkg::FarLimit)) ||
                 (32'(mag_y) > 32'(pgc_pkg::FarLimit));

  assign sq_x    = pgc_pkg::SqBits'(pgc_pkg::MagBits'(mag_x)) *
                   pgc_pkg::SqBits'(pgc_pkg::MagBits'(mag_x));
  assign sq_y    = pgc_pkg::SqBits'(pgc_pkg::MagBits'(mag_y)) *
                   pgc_pkg::SqBits'(pgc_pkg::MagBits'(mag_y));
  assign dist_sq = (pgc_pkg::SqBits+1)'(sq_x) + (pgc_pkg::SqBits+1)'(sq_y);
  assign close   = anchor_valid_q && !far &&
                   (dist_sq < (pgc_pkg::SqBits+1)'(radius_sq_q));

  // Elapsed ticks after a tick, held at all ones once it gets there.
  logic [pgc_pkg::TickBits-1:0] elapsed_inc;
  logic                         ticks_short;
  logic                         ticks_over;

  assign elapsed_inc = (elapsed_q == '1) ? elapsed_q : elapsed_q + 1'b1;
  assign ticks_short = 32'(elapsed_q) < 32'(long_ticks_q);
  assign ticks_over  = 32'(elapsed_inc) > 32'(long_ticks_q);

  // ---------------------------------------------------------------------------
  // Classification. An event gives up to two results: a click, then the end of
  // a long press or a drag.
  // ---------------------------------------------------------------------------
  pgc_pkg::result_t res0, res1;
  logic [1:0]       n_res;

  function automatic pgc_pkg::result_t make_res(pgc_pkg::gesture_e g,
                                                logic signed [C-1:0] x,
                                                logic signed [C-1:0] y,
                                                logic signed [C:0] ox,
                                                logic signed [C:0] oy);
    pgc_pkg::result_t r;
    r.gesture  = g;
    r.out_x    = x;
    r.out_y    = y;
    r.offset_x = ox;
    r.offset_y = oy;
    r.last     = 1'b1;
    return r;
  endfunction

  always_comb begin
    anchor_x_d     = anchor_x_q;
    anchor_y_d     = anchor_y_q;
    anchor_valid_d = anchor_valid_q;
    elapsed_d      = elapsed_q;
    long_active_d  = long_active_q;
    drag_active_d  = drag_active_q;
    res0  = make_res(pgc_pkg::GClick, pos_x_q, pos_y_q, '0, '0);
    res1  = res0;
    n_res = 2'd0;

    unique case (pgc_pkg::cmd_e'(cmd_q))
      pgc_pkg::CmdDown: begin
        // Any button press that is not consumed restarts the anchor.
        if (!consumed_q) begin
          anchor_x_d     = pos_x_q;
          anchor_y_d     = pos_y_q;
          anchor_valid_d = 1'b1;
          elapsed_d      = '0;
        end
      end
      pgc_pkg::CmdUp: begin
        if (is_left_q) begin
          if (!consumed_q) begin
            if (close && ticks_short) begin
              res0  = make_res(pgc_pkg::GClick, pos_x_q, pos_y_q, '0, '0);
              n_res = 2'd1;
              if (long_active_q || drag_active_q) begin
                res0.last = 1'b0;
                res1  = make_res(long_active_q ? pgc_pkg::GLongEnd : pgc_pkg::GDragEnd,
                                 pos_x_q, pos_y_q, '0, '0);
                n_res = 2'd2;
              end
            end else if (long_active_q || drag_active_q) begin
              res0  = make_res(long_active_q ? pgc_pkg::GLongEnd : pgc_pkg::GDragEnd,
                               pos_x_q, pos_y_q, '0, '0);
              n_res = 2'd1;
            end
          end
          long_active_d  = 1'b0;
          drag_active_d  = 1'b0;
          anchor_valid_d = 1'b0;
        end
      end
      pgc_pkg::CmdMotion: begin
        if (!consumed_q && left_held_q) begin
          if (long_active_q) begin
            res0  = make_res(pgc_pkg::GLongMotion, pos_x_q, pos_y_q, '0, '0);
            n_res = 2'd1;
          end else if (anchor_valid_q && !close && !drag_active_q) begin
            res0          = make_res(pgc_pkg::GDragBegin, pos_x_q, pos_y_q, dx, dy);
            n_res         = 2'd1;
            drag_active_d = 1'b1;
          end else if (drag_active_q) begin
            res0  = make_res(pgc_pkg::GDragMotion, pos_x_q, pos_y_q, '0, '0);
            n_res = 2'd1;
          end
        end
      end
      pgc_pkg::CmdTick: begin
        elapsed_d = elapsed_inc;
        if (left_held_q && !long_active_q && !drag_active_q && ticks_over) begin
          res0          = make_res(pgc_pkg::GLongBegin, pos_x_q, pos_y_q, '0, '0);
          n_res         = 2'd1;
          long_active_d = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Result queue. Classification needs room for two results before it fires,
  // so the input register only waits while three or more results are queued.
  // ---------------------------------------------------------------------------
  pgc_pkg::result_t                 fifo_q [pgc_pkg::FifoDepth];
  logic [pgc_pkg::FifoAw-1:0]       wr_ptr_q, rd_ptr_q;
  logic [pgc_pkg::FifoAw:0]         count_q;
  logic [1:0]                       n_push;
  logic                             pop;
  pgc_pkg::result_t                 head;

  assign space_ok = count_q <= (pgc_pkg::FifoAw+1)'(pgc_pkg::FifoDepth - 2);
  assign n_push   = fire ? n_res : 2'd0;
  assign pop      = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + pgc_pkg::FifoAw'(n_push);
      rd_ptr_q <= rd_ptr_q + pgc_pkg::FifoAw'(pop);
      count_q  <= count_q + (pgc_pkg::FifoAw+1)'(n_push) - (pgc_pkg::FifoAw+1)'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (n_push != 2'd0) begin
      fifo_q[wr_ptr_q] <= res0;
    end
    if (n_push == 2'd2) begin
      fifo_q[wr_ptr_q + pgc_pkg::FifoAw'(1)] <= res1;
    end
  end

  assign head        = fifo_q[rd_ptr_q];
  assign out_valid_o = count_q != '0;
  assign gesture_o   = head.gesture;
  assign out_x_o     = head.out_x;
  assign out_y_o     = head.out_y;
  assign offset_x_o  = head.offset_x;
  assign offset_y_o  = head.offset_y;
  assign last_o      = head.last;

endmodule

// ----- rtl/pgc_checker.sv -----
// Port-level checker for the pointer gesture classifier, bound to the top level.
// Depends on pgc_pkg for widths and gesture codes.
module pgc_checker (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 out_valid_o,
  input logic                                 out_ready_i,
  input logic [2:0]                           gesture_o,
  input logic signed [pgc_pkg::CoordBits-1:0] out_x_o,
  input logic signed [pgc_pkg::CoordBits-1:0] out_y_o,
  input logic signed [pgc_pkg::CoordBits:0]   offset_x_o,
  input logic signed [pgc_pkg::CoordBits:0]   offset_y_o,
  input logic                                 last_o
);

  // A stalled result keeps its contents.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(gesture_o) &&
      $stable(out_x_o) && $stable(out_y_o) && $stable(last_o))
    else $error("result changed while stalled");

  // Only a drag begin carries an offset.
  a_offset_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && gesture_o != pgc_pkg::GDragBegin |-> offset_x_o == '0 && offset_y_o == '0)
    else $error("offset on a gesture other than drag begin");

  // Only a click can be followed by a second result of the same event.
  a_last_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && gesture_o != pgc_pkg::GClick |-> last_o)
    else $error("non-click result not marked last");

  // A click that is not last is followed by the end of a long press or drag.
  a_click_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && gesture_o == pgc_pkg::GClick && !last_o |=>
      out_valid_o && (gesture_o == pgc_pkg::GLongEnd || gesture_o == pgc_pkg::GDragEnd))
    else $error("click not followed by its end gesture");

endmodule

bind pointer_gesture_classifier pgc_checker u_pgc_checker (.*);
